// ===== design/l2vn_pkg.sv =====
// ---------------------------------------------------------------------------
// l2vn_pkg: shared types and constants of the L2 vector normalizer
// Widths of the datapath and the descriptor passed from front to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package l2vn_pkg;

  localparam int ELEM_W  = 16;
  localparam int SUM_W   = 37;
  localparam int CNT_W   = 7;    // holds a vector length up to 64
  localparam int SCALE_W = 32;
  localparam int ACC_W   = 106;  // inverse root search accumulators
  localparam int PROD_W  = 49;   // 17-bit magnitude times 32-bit scale

  // One finished vector, handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic             bank;
  } vec_desc_t;

  // Release of a store bank once all its elements are emitted
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

endpackage
`default_nettype wire

// ===== design/l2vn_ram.sv =====
// ---------------------------------------------------------------------------
// l2vn_ram: generic single write, single read memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module l2vn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/l2vn_front.sv =====
// ---------------------------------------------------------------------------
// l2vn_front: element intake
// Stores elements into the free bank, sums their squares and hands a
// descriptor of each finished vector to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module l2vn_front #(
  parameter int MAX_LEN = 64,
  parameter int IW      = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic signed [15:0]         element,
  input  wire logic                       last,
  output logic                            in_stall,
  output logic                            ram_we,
  output logic             [IW:0]         ram_waddr,
  output logic             [15:0]         ram_wdata,
  output logic                            desc_valid,
  output l2vn_pkg::vec_desc_t             desc,
  input  wire logic                       q_ready,
  input  wire l2vn_pkg::bank_free_t       bank_free
);
  import l2vn_pkg::*;

  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             bank;
  logic [1:0]       bank_busy;
  logic [1:0]       bank_busy_next;

  logic               accept;
  logic               room;
  logic signed [31:0] sq;
  logic [SUM_W-1:0]   sum_add;
  logic [CNT_W-1:0]   count_add;

  // Hold input while the current bank is still being emitted or the queue is full
  assign in_stall  = bank_busy[bank] || !q_ready;
  assign accept    = in_valid && !in_stall;
  assign room      = count < CNT_W'(MAX_LEN);
  assign sq        = element * element;
  assign sum_add   = sum + {{(SUM_W-32){1'b0}}, sq};
  assign count_add = count + CNT_W'(1);

  assign ram_we    = accept && room;
  assign ram_waddr = {bank, count[IW-1:0]};
  assign ram_wdata = element;

  // Descriptor of the vector that this transfer closes
  assign desc_valid = accept && last;
  always_comb begin
    desc.sum   = room ? sum_add : sum;
    desc.count = room ? count_add : count;
    desc.ovf   = ovf || !room;
    desc.bank  = bank;
  end

  // Release a bank once emitted, claim it when its vector closes
  always_comb begin
    bank_busy_next = bank_busy;
    if (bank_free.valid) begin
      bank_busy_next[bank_free.bank] = 1'b0;
    end
    if (accept && last) begin
      bank_busy_next[bank] = 1'b1;
    end
  end

  // Accumulate, drop past the limit, flip banks at the end of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      bank      <= 1'b0;
      bank_busy <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      if (accept) begin
        if (last) begin
          sum   <= '0;
          count <= '0;
          ovf   <= 1'b0;
          bank  <= ~bank;
        end else if (room) begin
          sum   <= sum_add;
          count <= count_add;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/l2vn_queue.sv =====
// ---------------------------------------------------------------------------
// l2vn_queue: two-entry descriptor queue
// Decouples element intake from the normalize and emit pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module l2vn_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  input  wire l2vn_pkg::vec_desc_t  push_data,
  output logic                      push_ready,
  output logic                      pop_valid,
  output l2vn_pkg::vec_desc_t       pop_data,
  input  wire logic                 pop_take
);
  import l2vn_pkg::*;

  vec_desc_t  entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_data   = entry[rptr];

  // Write entries
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      entry[wptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push_valid && push_ready) begin
        wptr <= ~wptr;
      end
      if (pop_take && pop_valid) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push_valid && push_ready) - 2'(pop_take && pop_valid);
    end
  end

endmodule
`default_nettype wire

// ===== design/l2vn_back.sv =====
// ---------------------------------------------------------------------------
// l2vn_back: inverse root and emit pass
// Finds the Q16.16 inverse norm one bit per trial and check state, then replays the
// stored elements scaled, rounded and saturated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module l2vn_back #(
  parameter int IW = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  desc_valid,
  input  wire l2vn_pkg::vec_desc_t   desc,
  output logic                       desc_take,
  output logic        [IW:0]         ram_raddr,
  input  wire logic   [15:0]         ram_rdata,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [15:0]         value,
  output logic        [31:0]         scale,
  output logic                       overflowed,
  output logic                       end_of_run,
  output l2vn_pkg::bank_free_t       bank_free
);
  import l2vn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRY, ST_CHECK, ST_READ, ST_MUL, ST_OUT, ST_WAIT
  } state_t;

  localparam logic [ACC_W-1:0] LIMIT = ACC_W'(1) << 64;

  state_t             state;
  vec_desc_t          cur;
  logic [ACC_W-1:0]   a_acc, b_acc, a_try, b_try;
  logic [SCALE_W-1:0] k;
  logic [4:0]         j;
  logic [SCALE_W-1:0] scale_r;
  logic [CNT_W-1:0]   idx;
  logic [PROD_W-1:0]  prod;
  logic               neg;
  logic [15:0]        elem_q;

  logic [ACC_W-1:0]   s_ext;
  logic [ACC_W-1:0]   t_val;
  logic               fits;
  logic [SCALE_W-1:0] k_next;
  logic               zero_sum;
  logic [16:0]        mag;
  logic [PROD_W-1:0]  rnd;
  logic [32:0]        p;
  logic [16:0]        pc;
  logic [15:0]        y;
  logic               is_end;

  assign s_ext     = ACC_W'(cur.sum);
  assign zero_sum  = cur.sum == '0;
  assign desc_take = (state == ST_IDLE) && desc_valid;
  assign ram_raddr = {cur.bank, idx[IW-1:0]};
  assign is_end    = CNT_W'(idx + CNT_W'(1)) == cur.count;

  // Trial test: (2k-1)^2 * S <= 2^64 with A = k^2*S, B = k*S
  assign t_val  = ((a_try - b_try) << 2) + s_ext;
  assign fits   = t_val <= LIMIT;
  assign k_next = fits ? (k | (SCALE_W'(1) << j)) : k;

  // Element magnitude and rounding to Q1.15 with saturation
  assign mag = ram_rdata[15] ? (17'd0 - {1'b1, ram_rdata}) : {1'b0, ram_rdata};
  assign rnd = prod + PROD_W'(32768);
  assign p   = rnd[PROD_W-1:16];
  assign pc  = (p > 33'd32768) ? 17'd32768 : p[16:0];
  always_comb begin
    if (neg) begin
      y = 16'(17'd0 - pc);
    end else if (pc > 17'd32767) begin
      y = 16'h7FFF;
    end else begin
      y = pc[15:0];
    end
  end

  // Release the bank when the last result is taken
  assign bank_free.valid = (state == ST_WAIT) && !out_stall && end_of_run;
  assign bank_free.bank  = cur.bank;

  // Sequencer: search the inverse root, then emit one element at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (desc_valid) begin
            cur   <= desc;
            a_acc <= '0;
            b_acc <= '0;
            k     <= '0;
            j     <= 5'd31;
            idx   <= '0;
            if (desc.sum == '0) begin
              scale_r <= '0;
              state   <= ST_READ;
            end else begin
              state <= ST_TRY;
            end
          end
        end
        ST_TRY: begin
          a_try <= a_acc + (b_acc << (6'(j) + 6'd1)) + (s_ext << {j, 1'b0});
          b_try <= b_acc + (s_ext << j);
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (fits) begin
            a_acc <= a_try;
            b_acc <= b_try;
          end
          k <= k_next;
          if (j == 5'd0) begin
            scale_r <= k_next;
            state   <= ST_READ;
          end else begin
            j     <= j - 5'd1;
            state <= ST_TRY;
          end
        end
        ST_READ: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          elem_q <= ram_rdata;
          neg    <= ram_rdata[15];
          prod   <= mag * scale_r;
          state  <= ST_OUT;
        end
        ST_OUT: begin
          value      <= zero_sum ? elem_q : y;
          scale      <= scale_r;
          overflowed <= cur.ovf;
          end_of_run <= is_end;
          out_valid  <= 1'b1;
          state      <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (end_of_run) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_desc_nonempty: assert property (@(posedge clk) disable iff (rst)
    desc_take |-> desc.count != '0)
    else $error("empty vector descriptor taken");

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scale <= 32'h8000_0000)
    else $error("scale above 2^31");

  a_zero_scale: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_sum) |-> scale == '0)
    else $error("nonzero scale for zero sum");

endmodule
`default_nettype wire

// ===== design/l2_vector_normalizer_top.sv =====
// ---------------------------------------------------------------------------
// l2_vector_normalizer_top: L2 normalization of Q1.15 vectors
// Buffers a vector, takes the inverse norm and emits scaled elements.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  element, last
//   out      out_valid/ out_stall value, scale, overflowed, end_of_run
//
// Intake takes one element per cycle, unless in_stall is raised, into one of two store banks.
// For a nonzero sum the inverse root is found over 32 result bits, each by a trial and a check.
// Each element passes the store read, multiply, output and wait steps; the next is read once it is taken.
// The next vector loads into the other bank while one is emitted.
// Reset is synchronous; out_stall holds the current result in place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module l2_vector_normalizer_top #(
  parameter int MAX_LEN = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] element,
  input  wire logic               last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      value,
  output logic        [31:0]      scale,
  output logic                    overflowed,
  output logic                    end_of_run
);
  import l2vn_pkg::*;

  localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DEPTH = 2 ** (IW + 1);

  logic        ram_we;
  logic [IW:0] ram_waddr;
  logic [15:0] ram_wdata;
  logic [IW:0] ram_raddr;
  logic [15:0] ram_rdata;
  logic        push_valid;
  logic        push_ready;
  vec_desc_t   push_data;
  logic        pop_valid;
  logic        pop_take;
  vec_desc_t   pop_data;
  bank_free_t  bank_free;

  l2vn_front #(.MAX_LEN(MAX_LEN), .IW(IW)) u_front (
    .clk, .rst, .in_valid, .element, .last, .in_stall,
    .ram_we, .ram_waddr, .ram_wdata,
    .desc_valid(push_valid), .desc(push_data), .q_ready(push_ready),
    .bank_free
  );

  l2vn_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  l2vn_queue u_queue (
    .clk, .rst, .push_valid, .push_data, .push_ready,
    .pop_valid, .pop_data, .pop_take
  );

  l2vn_back #(.IW(IW)) u_back (
    .clk, .rst, .desc_valid(pop_valid), .desc(pop_data), .desc_take(pop_take),
    .ram_raddr, .ram_rdata, .out_valid, .out_stall,
    .value, .scale, .overflowed, .end_of_run, .bank_free
  );

endmodule
`default_nettype wire

// ===== tb/sv/l2_vector_normalizer_top_tb.sv =====
// ---------------------------------------------------------------------------
// l2_vector_normalizer_top_tb: self-checking bench for the L2 normalizer
// Feeds vectors of Q1.15 elements, predicts each scaled element and the
// inverse norm with a local model, and checks every output transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module l2_vector_normalizer_top_tb;
  import l2vn_pkg::*;

  localparam int MAX_LEN = 64;
  localparam int LIMIT   = 2000000;

  typedef struct {
    logic signed [15:0] value;
    logic [31:0]        scale;
    logic               overflowed;
    logic               end_of_run;
  } norm_out_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] element = '0;
  logic last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] value;
  logic [31:0] scale;
  logic overflowed;
  logic end_of_run;

  l2_vector_normalizer_top #(.MAX_LEN(MAX_LEN)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .element(element), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .value(value), .scale(scale),
    .overflowed(overflowed), .end_of_run(end_of_run)
  );

  // Predictor state for the vector being collected
  logic signed [15:0] vec_buf[MAX_LEN];
  logic [SUM_W-1:0]   vec_sum = '0;
  int                 vec_len = 0;
  logic               vec_drop = 0;
  norm_out_t          pending_q[$];
  int                 errors = 0;
  longint             cycles = 0;
  int                 gap_max = 3;
  int                 stall_pct = 30;

  initial forever #5 clk = ~clk;

  // round(2^31 / sqrt(s)), halves up, by binary search on (2k-1)^2 * s <= 2^64
  function automatic logic [31:0] inv_root(input logic [SUM_W-1:0] s);
    logic [63:0] lo, hi, mid;
    logic [127:0] d;
    lo = 1;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * s <= (128'd1 << 64)) lo = mid;
      else hi = mid - 1;
    end
    return lo[31:0];
  endfunction

  function automatic logic signed [15:0] scaled_elem(input logic signed [15:0] x,
                                                      input logic [31:0] f);
    longint mag, p;
    mag = (x < 0) ? -longint'(x) : longint'(x);
    p = (mag * longint'(f) + 32768) >>> 16;
    if (p > 32768) p = 32768;
    p = (x < 0) ? -p : p;
    if (p > 32767) p = 32767;
    return p[15:0];
  endfunction

  // Advance the predictor by one accepted element
  task automatic absorb(input logic signed [15:0] x, input logic lst);
    logic [31:0] f;
    norm_out_t r;
    longint sq;
    if (vec_len < MAX_LEN) begin
      vec_buf[vec_len] = x;
      sq = longint'(x) * longint'(x);
      vec_sum = vec_sum + sq[SUM_W-1:0];
      vec_len++;
    end else begin
      vec_drop = 1;
    end
    if (!lst) return;
    f = (vec_sum != 0) ? inv_root(vec_sum) : 32'd0;
    for (int i = 0; i < vec_len; i++) begin
      r.value = (vec_sum != 0) ? scaled_elem(vec_buf[i], f) : vec_buf[i];
      r.scale = f;
      r.overflowed = vec_drop;
      r.end_of_run = (i + 1 == vec_len);
      pending_q.push_back(r);
    end
    vec_sum = '0;
    vec_len = 0;
    vec_drop = 0;
  endtask

  task automatic report(input string what, input longint got, input longint exp);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycles);
  endtask

  // Send one element, then at random a gap
  task automatic send(input logic signed [15:0] x, input logic lst);
    element <= x;
    last <= lst;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb(x, lst);
    if ($urandom_range(0, 3) == 0 && gap_max > 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
    end
  endtask

  task automatic idle_in();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_elem(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 15) - 8);
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  task automatic send_vec(input int n, input int mode);
    for (int i = 0; i < n; i++) send(rand_elem(mode), i == n - 1);
  endtask

  // Extremes, single elements, zero sum and exact values
  task automatic test_directed();
    send(16'sh7fff, 1);
    send(16'sh8000, 1);
    send(16'sd1, 1);
    send(-16'sd1, 1);
    send(16'sd0, 1);
    send(16'sd0, 0); send(16'sd0, 0); send(16'sd0, 1);
    send(16'sd3, 0); send(16'sd4, 1);
    send(16'sh8000, 0); send(16'sh8000, 0); send(16'sh7fff, 1);
    send(16'sh5555, 0); send(16'shaaaa, 1);
    send(16'sd0, 0); send(-16'sd5, 1);
  endtask

  // Full-length vector and vectors past the limit, last on a dropped element
  task automatic test_overflow();
    send_vec(MAX_LEN, 0);
    send_vec(MAX_LEN + 1, 2);
    send_vec(MAX_LEN + 5, 0);
    send_vec(MAX_LEN, 1);
  endtask

  // Wait for the pipeline to empty before more traffic
  task automatic test_pause();
    send_vec(7, 0);
    send_vec(3, 1);
    drain();
    send_vec(5, 0);
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 120) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(MAX_LEN - 2, MAX_LEN + 3);
        default: n = $urandom_range(1, 12);
      endcase
      if ($urandom_range(0, 5) == 0) gap_max = 0;
      else gap_max = $urandom_range(1, 8);
      send_vec(n, $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0);
      sent += n;
    end
  endtask

  // Stall the output in its own pattern, with quiet stretches
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) out_stall <= 0;
    else if (cycles % 2000 < 400) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check every output transfer against the oldest prediction
  always @(posedge clk) begin
    norm_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected output transfer at cycle %0d", cycles);
      end else begin
        e = pending_q.pop_front();
        if (value !== e.value) report("value", value, e.value);
        if (scale !== e.scale) report("scale", scale, e.scale);
        if (overflowed !== e.overflowed) report("overflowed", overflowed, e.overflowed);
        if (end_of_run !== e.end_of_run) report("end_of_run", end_of_run, e.end_of_run);
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycles >= LIMIT);
    $display("FAIL l2_vector_normalizer_top");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_pause();
    stall_pct = 70;
    test_random();
    stall_pct = 20;
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("PASS l2_vector_normalizer_top");
    end else begin
      $display("FAIL l2_vector_normalizer_top");
    end
    $finish;
  end

endmodule

// ===== l2_vector_normalizer_top.f =====
design/l2vn_pkg.sv
design/l2vn_ram.sv
design/l2vn_front.sv
design/l2vn_queue.sv
design/l2vn_back.sv
design/l2_vector_normalizer_top.sv
tb/sv/l2_vector_normalizer_top_tb.sv
